// ===== rtl/twst_pkg.sv =====
package twst_pkg;

  // Temperature values are 1/256 degree units
  localparam int unsigned TEMP_W       = 17;
  localparam int unsigned ADC_W        = 10;
  localparam int unsigned SCALE_FACTOR = 125;
  localparam int unsigned MIN_RESET    = 32000;

  // Window default depth
  localparam int unsigned WINDOW_LEN_DEF = 60;

  // Configuration registers
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MODE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SAMPLE = 1'd1;

  localparam int unsigned MODE_W = 4;
  localparam int unsigned TICK_W = 8;
  localparam logic [MODE_W-1:0] MODE_RESET  = 4'd1;
  localparam logic [TICK_W-1:0] TICKS_RESET = 8'd62;

  // Display modes; any other code shows the average
  localparam logic [MODE_W-1:0] DISP_CURRENT = 4'd1;
  localparam logic [MODE_W-1:0] DISP_MAX     = 4'd2;
  localparam logic [MODE_W-1:0] DISP_MIN     = 4'd3;

  // Request kinds
  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned OUT_USER_W = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_DONE
  } twst_state_e;

endpackage

// ===== rtl/temperature_window_statistics.sv =====
// Channel   | Dir | tdata                                          | tuser
// s_axis    | in  | [9:0] adc_sample, [15:10] zero                 | [0] req_type
// m_axis    | out | [16:0] current_temp, [33:17] max_temp,         | [0] sample_taken,
//           |     | [50:34] min_temp, [67:51] avg_temp,            | [1] display_due
//           |     | [84:68] shown_value, [87:85] zero              |
// cfg       | in  | cfg_we_i, cfg_index_i (0 display_mode, 1 ticks_per_sample), cfg_wdata_i
//
// A tick or an ignored sample goes from the idle state straight to the done state.
// A taken sample passes through the update and divide states first; the mean comes
// from a restoring divider that retires one quotient bit per cycle.
// The input is ready only in the idle state; a finished result waits in the
// output register while the next item is taken in.
// Reset (rst_ni low) clears counters, armed and valid flags and statistics, but sets the
// minimum to MIN_RESET; window entries are undefined until written and used only when full.
module temperature_window_statistics #(
  parameter int unsigned WINDOW_LEN = twst_pkg::WINDOW_LEN_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // [9:0] adc_sample, [15:10] zero
  input  logic [twst_pkg::IN_DATA_W-1:0]        s_axis_tdata_i,
  // [0] req_type
  input  logic                                  s_axis_tuser_i,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [16:0] current, [33:17] max, [50:34] min, [67:51] avg, [84:68] shown
  output logic [twst_pkg::OUT_DATA_W-1:0]       m_axis_tdata_o,
  // [0] sample_taken, [1] display_due
  output logic [twst_pkg::OUT_USER_W-1:0]       m_axis_tuser_o,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  input  logic                                  cfg_we_i,
  input  logic [twst_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [twst_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  localparam int unsigned TEMP_W = twst_pkg::TEMP_W;
  localparam int unsigned POS_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int unsigned SUM_W  = TEMP_W + CNT_W;
  localparam int unsigned DIV_W  = $clog2(SUM_W);
  localparam int unsigned PAD_W  = twst_pkg::OUT_DATA_W - 5 * TEMP_W;

  twst_pkg::twst_state_e state_q, state_d;

  logic [twst_pkg::MODE_W-1:0] mode_q;
  logic [twst_pkg::TICK_W-1:0] tps_q;
  logic [twst_pkg::TICK_W-1:0] tick_q;
  logic                        armed_q;
  logic [POS_W-1:0]            wpos_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [SUM_W-1:0]            sum_q;
  logic [TEMP_W-1:0]           cur_q, max_q, min_q, avg_q;

  logic [TEMP_W-1:0]           mem_q [WINDOW_LEN];
  logic [TEMP_W-1:0]           rd_q;
  logic [TEMP_W-1:0]           temp_q;
  logic                        taken_q, due_q;

  logic [SUM_W-1:0]            quo_q;
  logic [CNT_W-1:0]            rem_q;
  logic [DIV_W-1:0]            div_cnt_q;

  logic                        out_valid_q;
  logic [TEMP_W-1:0]           o_cur_q, o_max_q, o_min_q, o_avg_q, o_shown_q;
  logic [1:0]                  o_flags_q;

  // Control outputs of the sequencer
  logic in_ready, mem_we, div_last, out_load;

  logic                        accept, is_sample, take;
  logic [twst_pkg::TICK_W-1:0] tick_inc;
  logic                        fire;
  logic [TEMP_W-1:0]           temp_in;
  logic                        full;
  logic [SUM_W-1:0]            sum_new;
  logic [CNT_W:0]              rem_sh, rem_sub;
  logic                        rem_ge;
  logic [CNT_W-1:0]            rem_next;
  logic [SUM_W-1:0]            quo_next;
  logic [TEMP_W-1:0]           shown;

  // Input side decode
  assign accept    = s_axis_tvalid_i & s_axis_tready_o;
  assign is_sample = (s_axis_tuser_i == twst_pkg::REQ_SAMPLE);
  assign take      = accept & is_sample & armed_q;
  assign tick_inc  = tick_q + 1'b1;
  assign fire      = (tick_inc >= tps_q);
  assign temp_in   = TEMP_W'(s_axis_tdata_i[twst_pkg::ADC_W-1:0])
                   * TEMP_W'(twst_pkg::SCALE_FACTOR);

  // Window sum update: drop the oldest entry once the ring is full
  assign full    = (cnt_q == CNT_W'(WINDOW_LEN));
  assign sum_new = sum_q - (full ? SUM_W'(rd_q) : '0) + SUM_W'(temp_q);

  // Restoring divider step, one quotient bit per cycle
  assign rem_sh   = {rem_q, quo_q[SUM_W-1]};
  assign rem_sub  = rem_sh - {1'b0, cnt_q};
  assign rem_ge   = (rem_sh >= {1'b0, cnt_q});
  assign rem_next = rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
  assign quo_next = {quo_q[SUM_W-2:0], rem_ge};

  // Display selection
  always_comb begin
    unique case (mode_q)
      twst_pkg::DISP_CURRENT: shown = cur_q;
      twst_pkg::DISP_MAX:     shown = max_q;
      twst_pkg::DISP_MIN:     shown = min_q;
      default:                shown = avg_q;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      twst_pkg::ST_IDLE: begin
        if (accept) state_d = take ? twst_pkg::ST_UPDATE : twst_pkg::ST_DONE;
      end
      twst_pkg::ST_UPDATE: state_d = twst_pkg::ST_DIV;
      twst_pkg::ST_DIV: begin
        if (div_cnt_q == '0) state_d = twst_pkg::ST_DONE;
      end
      twst_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) state_d = twst_pkg::ST_IDLE;
      end
      default: state_d = twst_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    div_last = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      twst_pkg::ST_IDLE:   in_ready = 1'b1;
      twst_pkg::ST_UPDATE: mem_we   = 1'b1;
      twst_pkg::ST_DIV:    div_last = (div_cnt_q == '0);
      twst_pkg::ST_DONE:   out_load = !out_valid_q || m_axis_tready_i;
      default:   ;
    endcase
  end

  assign s_axis_tready_o = in_ready;

  // Control and statistics registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= twst_pkg::ST_IDLE;
      mode_q      <= twst_pkg::MODE_RESET;
      tps_q       <= twst_pkg::TICKS_RESET;
      tick_q      <= '0;
      armed_q     <= 1'b0;
      wpos_q      <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      cur_q       <= '0;
      max_q       <= '0;
      min_q       <= TEMP_W'(twst_pkg::MIN_RESET);
      avg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Configuration writes
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          twst_pkg::REG_DISPLAY_MODE:     mode_q <= cfg_wdata_i[twst_pkg::MODE_W-1:0];
          twst_pkg::REG_TICKS_PER_SAMPLE: tps_q  <= cfg_wdata_i[twst_pkg::TICK_W-1:0];
          default: ;
        endcase
      end
      // Tick counting and arming
      if (accept && !is_sample) begin
        if (fire) begin
          tick_q  <= '0;
          armed_q <= 1'b1;
        end else begin
          tick_q <= tick_inc;
        end
      end
      if (take) armed_q <= 1'b0;
      // Statistics update; min and max tested independently
      if (mem_we) begin
        cur_q <= temp_q;
        if (temp_q < min_q) min_q <= temp_q;
        if (temp_q > max_q) max_q <= temp_q;
        sum_q <= sum_new;
        if (!full) cnt_q <= cnt_q + 1'b1;
        wpos_q <= (wpos_q == POS_W'(WINDOW_LEN - 1)) ? '0 : wpos_q + 1'b1;
      end
      if (div_last) avg_q <= quo_next[TEMP_W-1:0];
      // Output register handshake
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      temp_q  <= temp_in;
      taken_q <= take;
      due_q   <= !is_sample && fire;
    end
    if (mem_we) begin
      quo_q     <= sum_new;
      rem_q     <= '0;
      div_cnt_q <= DIV_W'(SUM_W - 1);
    end else if (state_q == twst_pkg::ST_DIV) begin
      quo_q     <= quo_next;
      rem_q     <= rem_next;
      div_cnt_q <= div_cnt_q - 1'b1;
    end
    if (out_load) begin
      o_cur_q   <= cur_q;
      o_max_q   <= max_q;
      o_min_q   <= min_q;
      o_avg_q   <= avg_q;
      o_shown_q <= shown;
      o_flags_q <= {due_q, taken_q};
    end
  end

  // Window ring: registered read of the entry about to be replaced
  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[wpos_q];
    if (mem_we) mem_q[wpos_q] <= temp_q;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = o_flags_q;
  assign m_axis_tdata_o  = {{PAD_W{1'b0}}, o_shown_q, o_avg_q, o_min_q, o_max_q, o_cur_q};

  // Fill count never passes the window depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(WINDOW_LEN))
    else $error("fill count beyond window depth");

  // Write position stays inside the ring
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpos_q <= POS_W'(WINDOW_LEN - 1))
    else $error("write position outside window");

  // Once a sample was taken, minimum never exceeds maximum
  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (min_q <= max_q))
    else $error("minimum above maximum");

  // Mean lies between minimum and maximum when the divider is done
  a_avg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == twst_pkg::ST_IDLE && cnt_q != '0) |->
      (avg_q <= max_q && avg_q >= min_q))
    else $error("mean outside min/max range");

  // A taken sample always runs through the update step next
  a_take_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (state_q == twst_pkg::ST_UPDATE))
    else $error("taken sample skipped update");

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TEMP_W     = twst_pkg::TEMP_W;
  localparam int unsigned ADC_W      = twst_pkg::ADC_W;
  localparam int unsigned MODE_W     = twst_pkg::MODE_W;
  localparam int unsigned TICK_W     = twst_pkg::TICK_W;
  localparam int unsigned CFG_IDX_W  = twst_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = twst_pkg::CFG_DATA_W;
  localparam int unsigned IN_DATA_W  = twst_pkg::IN_DATA_W;
  localparam int unsigned OUT_DATA_W = twst_pkg::OUT_DATA_W;
  localparam int unsigned OUT_USER_W = twst_pkg::OUT_USER_W;

  localparam int unsigned RING_LEN    = twst_pkg::WINDOW_LEN_DEF;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_ITEMS = 1400;

  // Average shown for any mode code outside current/max/min
  localparam logic [MODE_W-1:0] DISP_AVG_ZERO = 4'd0;
  localparam logic [MODE_W-1:0] DISP_AVG_TOP  = 4'd15;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_e;

  typedef struct packed {
    logic              sample_taken;
    logic              display_due;
    logic [TEMP_W-1:0] current_temp;
    logic [TEMP_W-1:0] max_temp;
    logic [TEMP_W-1:0] min_temp;
    logic [TEMP_W-1:0] avg_temp;
    logic [TEMP_W-1:0] shown_value;
  } readout_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                  s_axis_tuser_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [OUT_USER_W-1:0] m_axis_tuser_o;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  temperature_window_statistics dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // Predictor state: configuration, statistics and the sample ring
  logic [MODE_W-1:0] disp_mode;
  logic [TICK_W-1:0] tick_rate;
  logic [TICK_W-1:0] tick_cnt;
  logic              read_armed;
  logic [TEMP_W-1:0] ring_temp [RING_LEN];
  int unsigned       ring_pos;
  int unsigned       ring_fill;
  int unsigned       ring_sum;
  logic [TEMP_W-1:0] cur_temp;
  logic [TEMP_W-1:0] hi_temp;
  logic [TEMP_W-1:0] lo_temp;
  logic [TEMP_W-1:0] mean_temp;

  readout_t    readout_q [$];
  readout_t    got_out;
  readout_t    want_out;
  int unsigned fault_cnt;
  int unsigned items_sent;
  int unsigned samples_taken;
  int unsigned refreshes;
  int unsigned phases_run;
  int unsigned cycle_cnt;

  // Sender and receiver idling controls
  int unsigned burst_max;
  int unsigned burst_left;
  int unsigned gap_max;
  stall_e      stall_mode;
  int unsigned stall_cnt;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Work out the result of one accepted transfer and advance the predictor
  function automatic readout_t predict_reading(input logic req,
                                               input logic [ADC_W-1:0] adc);
    readout_t    r;
    int unsigned scaled;
    logic [TEMP_W-1:0] temp;
    r = '0;
    if (req == twst_pkg::REQ_TICK) begin
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt >= tick_rate) begin
        tick_cnt      = '0;
        read_armed    = 1'b1;
        r.display_due = 1'b1;
        refreshes++;
      end
    end else if (read_armed) begin
      read_armed = 1'b0;
      scaled     = adc * twst_pkg::SCALE_FACTOR;
      temp       = scaled[TEMP_W-1:0];
      cur_temp   = temp;
      if (temp < lo_temp) lo_temp = temp;
      if (temp > hi_temp) hi_temp = temp;
      // Retire the oldest entry once the ring is full
      if (ring_fill < RING_LEN) begin
        ring_fill++;
      end else begin
        ring_sum -= ring_temp[ring_pos];
      end
      ring_temp[ring_pos] = temp;
      ring_sum += temp;
      scaled    = ring_sum / ring_fill;
      mean_temp = scaled[TEMP_W-1:0];
      ring_pos  = (ring_pos == RING_LEN - 1) ? 0 : ring_pos + 1;
      r.sample_taken = 1'b1;
      samples_taken++;
    end
    r.current_temp = cur_temp;
    r.max_temp     = hi_temp;
    r.min_temp     = lo_temp;
    r.avg_temp     = mean_temp;
    case (disp_mode)
      twst_pkg::DISP_CURRENT: r.shown_value = cur_temp;
      twst_pkg::DISP_MAX:     r.shown_value = hi_temp;
      twst_pkg::DISP_MIN:     r.shown_value = lo_temp;
      default:                r.shown_value = mean_temp;
    endcase
    return r;
  endfunction

  // Bias converter readings toward both ends of the range
  function automatic logic [ADC_W-1:0] rand_adc();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return ADC_W'($urandom_range(0, (1 << ADC_W) - 1));
  endfunction

  // Send one transfer; called and returning at a falling edge
  task automatic send_reading(input logic req, input logic [ADC_W-1:0] adc);
    s_axis_tuser_i  = req;
    s_axis_tdata_i  = {{(IN_DATA_W - ADC_W){1'b0}}, adc};
    s_axis_tvalid_i = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    readout_q.push_back(predict_reading(req, adc));
    items_sent++;
    @(negedge clk_i);
    if (burst_left > 0 || gap_max == 0) begin
      if (burst_left > 0) burst_left--;
    end else begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, gap_max)) @(negedge clk_i);
      burst_left = $urandom_range(0, burst_max);
    end
  endtask

  // Drop valid and wait for every expected result to come back
  task automatic drain_results();
    s_axis_tvalid_i = 1'b0;
    while (readout_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write one register while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain_results();
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == twst_pkg::REG_DISPLAY_MODE) disp_mode = val[MODE_W-1:0];
    else tick_rate = val[TICK_W-1:0];
  endtask

  // Send ticks up to and including the one that the predictor says arms a read
  task automatic send_ticks_to_fire();
    int unsigned need;
    need = (tick_cnt >= tick_rate) ? 1 : tick_rate - tick_cnt;
    repeat (need) send_reading(twst_pkg::REQ_TICK, rand_adc());
  endtask

  task automatic test_reset_state();
    // Unarmed sample is ignored; a lone tick stays below the default rate
    send_reading(twst_pkg::REQ_SAMPLE, 10'd512);
    send_reading(twst_pkg::REQ_TICK, '1);
  endtask

  task automatic test_min_max_and_firing();
    // Rate lowered to the tick count: the next tick fires at once
    write_reg(twst_pkg::REG_TICKS_PER_SAMPLE, 8'd1);
    send_reading(twst_pkg::REQ_TICK, '0);
    // First sample moves both minimum and maximum
    send_reading(twst_pkg::REQ_SAMPLE, 10'd200);
    // Two firings before one sample arm only one read
    send_reading(twst_pkg::REQ_TICK, '0);
    send_reading(twst_pkg::REQ_TICK, '0);
    send_reading(twst_pkg::REQ_SAMPLE, '1);
    send_reading(twst_pkg::REQ_SAMPLE, '0);
    send_reading(twst_pkg::REQ_TICK, '1);
    send_reading(twst_pkg::REQ_SAMPLE, '0);
  endtask

  task automatic test_display_modes();
    logic [MODE_W-1:0] modes [5];
    modes = '{twst_pkg::DISP_MAX, twst_pkg::DISP_MIN, DISP_AVG_ZERO, DISP_AVG_TOP,
              twst_pkg::DISP_CURRENT};
    foreach (modes[i]) begin
      write_reg(twst_pkg::REG_DISPLAY_MODE, CFG_DATA_W'(modes[i]));
      send_reading(twst_pkg::REQ_TICK, '0);
      send_reading(twst_pkg::REQ_SAMPLE, rand_adc());
    end
  endtask

  task automatic test_rate_lowered();
    write_reg(twst_pkg::REG_TICKS_PER_SAMPLE, 8'd255);
    repeat (5) send_reading(twst_pkg::REQ_TICK, '0);
    write_reg(twst_pkg::REG_TICKS_PER_SAMPLE, 8'd3);
    send_reading(twst_pkg::REQ_TICK, '0);
    send_reading(twst_pkg::REQ_SAMPLE, rand_adc());
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    int unsigned pick;
    int unsigned first_item;
    logic [TICK_W-1:0] rate;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      // New configuration for each phase
      pick = $urandom_range(0, 11);
      if (pick == 0) rate = twst_pkg::TICKS_RESET;
      else if (pick == 1) rate = TICK_W'($urandom_range(9, 40));
      else rate = TICK_W'($urandom_range(1, 6));
      write_reg(twst_pkg::REG_TICKS_PER_SAMPLE, rate);
      write_reg(twst_pkg::REG_DISPLAY_MODE, CFG_DATA_W'($urandom_range(0, 15)));
      if (phases_run == 0) begin
        gap_max    = 0;
        stall_mode = STALL_NONE;
      end else begin
        gap_max    = $urandom_range(0, 6);
        burst_max  = $urandom_range(0, 10);
        stall_mode = stall_e'($urandom_range(0, 3));
      end
      phases_run++;
      // Keep the last phase inside the item budget
      stop_at = items_sent + $urandom_range(100, 180);
      if (stop_at > first_item + RANDOM_ITEMS) stop_at = first_item + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          // Well-formed: ticks up to a firing, then one sample
          send_ticks_to_fire();
          send_reading(twst_pkg::REQ_SAMPLE, rand_adc());
        end else if (pick < 85) begin
          repeat ($urandom_range(1, 2 * rate)) send_reading(twst_pkg::REQ_TICK, rand_adc());
        end else if (pick < 93) begin
          send_reading(twst_pkg::REQ_SAMPLE, rand_adc());
        end else begin
          send_reading(($urandom_range(0, 1) == 0) ? twst_pkg::REQ_TICK : twst_pkg::REQ_SAMPLE,
                       rand_adc());
        end
      end
    end
  endtask

  // Receiver stall patterns
  always @(negedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    case (stall_mode)
      STALL_NONE:     m_axis_tready_i <= 1'b1;
      STALL_LIGHT:    m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: m_axis_tready_i <= ((stall_cnt % 7) < 4);
      default:        m_axis_tready_i <= ($urandom_range(0, 9) > 6);
    endcase
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_out.sample_taken = m_axis_tuser_o[0];
      got_out.display_due  = m_axis_tuser_o[1];
      got_out.current_temp = m_axis_tdata_o[0*TEMP_W +: TEMP_W];
      got_out.max_temp     = m_axis_tdata_o[1*TEMP_W +: TEMP_W];
      got_out.min_temp     = m_axis_tdata_o[2*TEMP_W +: TEMP_W];
      got_out.avg_temp     = m_axis_tdata_o[3*TEMP_W +: TEMP_W];
      got_out.shown_value  = m_axis_tdata_o[4*TEMP_W +: TEMP_W];
      if (readout_q.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= 10) $display("unexpected result transfer at cycle %0d", cycle_cnt);
      end else begin
        want_out = readout_q.pop_front();
        if (got_out !== want_out) begin
          fault_cnt++;
          if (fault_cnt <= 10) begin
            $display("mismatch at cycle %0d", cycle_cnt);
            $display("  exp taken=%0b due=%0b cur=%0d max=%0d min=%0d avg=%0d shown=%0d",
                     want_out.sample_taken, want_out.display_due, want_out.current_temp,
                     want_out.max_temp, want_out.min_temp, want_out.avg_temp,
                     want_out.shown_value);
            $display("  got taken=%0b due=%0b cur=%0d max=%0d min=%0d avg=%0d shown=%0d",
                     got_out.sample_taken, got_out.display_due, got_out.current_temp,
                     got_out.max_temp, got_out.min_temp, got_out.avg_temp,
                     got_out.shown_value);
          end
        end
      end
    end
  end

  // Hard limit on run length
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               readout_q.size());
      $display("** temperature_window_statistics: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = twst_pkg::REQ_TICK;
    s_axis_tvalid_i = 1'b0;
    m_axis_tready_i = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = twst_pkg::REG_DISPLAY_MODE;
    cfg_wdata_i     = '0;
    disp_mode       = twst_pkg::MODE_RESET;
    tick_rate       = twst_pkg::TICKS_RESET;
    tick_cnt        = '0;
    read_armed      = 1'b0;
    ring_pos        = 0;
    ring_fill       = 0;
    ring_sum        = 0;
    cur_temp        = '0;
    hi_temp         = '0;
    lo_temp         = TEMP_W'(twst_pkg::MIN_RESET);
    mean_temp       = '0;
    fault_cnt       = 0;
    items_sent      = 0;
    samples_taken   = 0;
    refreshes       = 0;
    phases_run      = 0;
    cycle_cnt       = 0;
    stall_cnt       = 0;
    burst_max       = 3;
    burst_left      = 0;
    gap_max         = 2;
    stall_mode      = STALL_LIGHT;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_min_max_and_firing();
    test_display_modes();
    test_rate_lowered();
    test_random_traffic();

    // Let the last results drain, then settle
    s_axis_tvalid_i = 1'b0;
    while (readout_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("covered %0d input transfers over %0d random phases: %0d samples taken",
             items_sent, phases_run, samples_taken);
    $display("%0d display refreshes, ring wrapped %0d times, %0d mismatches",
             refreshes, samples_taken / RING_LEN, fault_cnt);
    if (fault_cnt == 0 && readout_q.size() == 0) begin
      $display("** temperature_window_statistics: PASSED **");
    end else begin
      $display("** temperature_window_statistics: FAILED **");
    end
    $finish;
  end

endmodule
